@@ rtl/core/srz_pkg.sv @@
package srz_pkg;

  // Command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ROTATE = 3'd1;
  localparam logic [2:0] CMD_SEEK   = 3'd2;
  localparam logic [2:0] CMD_ABORT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic [2:0] STS_NONE      = 3'd0;
  localparam logic [2:0] STS_ACCEPTED  = 3'd1;
  localparam logic [2:0] STS_BUSY      = 3'd2;
  localparam logic [2:0] STS_DONE      = 3'd3;
  localparam logic [2:0] STS_ABORTED   = 3'd4;
  localparam logic [2:0] STS_ABORT_ACK = 3'd5;

  localparam logic [15:0] DELAY_RESET = 16'd50;
  localparam logic [3:0]  COILS_OFF   = 4'hF;

  // Motion mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_ROTATE = 3'b010,
    MODE_SEEK   = 3'b100
  } mode_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [7:0] step_count;
    logic              zero_sensor;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic [1:0] phase;
    logic [2:0] status;
  } res_item_t;

  typedef struct packed {
    logic [1:0]  phase_index;
    logic [7:0]  steps_left;
    logic        direction_down;
    mode_t       motion_mode;
    logic [15:0] delay_count;
    logic        abort_latched;
    logic [3:0]  coil_out;
  } motor_state_t;

  // Active-low wave-drive pattern for each phase
  function automatic logic [3:0] coil_for_phase(input logic [1:0] ph);
    logic [3:0] pat;
    case (ph)
      2'd0:    pat = 4'h7;
      2'd1:    pat = 4'hB;
      2'd2:    pat = 4'hD;
      default: pat = 4'hE;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/srz_step.sv @@
// Next-state and status logic for one item.
module srz_step import srz_pkg::*; (
  input  motor_state_t cur,
  input  cmd_item_t    item,
  input  logic [15:0]  step_delay_ticks,
  output motor_state_t nxt,
  output res_item_t    res
);

  logic [15:0] limit;
  logic [15:0] delay_inc;
  logic        step_due;
  logic [1:0]  phase_stepped;
  logic [7:0]  steps_dec;
  logic [2:0]  status;
  logic        moving;

  // Delay counting and the phase move it triggers
  assign limit         = (step_delay_ticks == 16'd0) ? 16'd1 : step_delay_ticks;
  assign delay_inc     = cur.delay_count + 16'd1;
  assign step_due      = (delay_inc >= limit);
  assign phase_stepped = cur.direction_down ? cur.phase_index - 2'd1
                                            : cur.phase_index + 2'd1;
  assign steps_dec     = cur.steps_left - 8'd1;
  assign moving        = (cur.motion_mode != MODE_IDLE);

  always_comb begin
    nxt    = cur;
    status = STS_NONE;
    case (item.cmd)
      CMD_ROTATE, CMD_SEEK: begin
        if (cur.abort_latched) begin
          status = STS_ABORTED;
        end else if (moving) begin
          status = STS_BUSY;
        end else if (item.cmd == CMD_ROTATE) begin
          if (item.step_count == 8'sd0) begin
            status = STS_DONE;
          end else begin
            nxt.direction_down = item.step_count[7];
            nxt.steps_left     = item.step_count[7] ? 8'd0 - item.step_count
                                                    : item.step_count;
            nxt.delay_count    = 16'd0;
            nxt.motion_mode    = MODE_ROTATE;
            status             = STS_ACCEPTED;
          end
        end else begin
          nxt.direction_down = 1'b0;
          nxt.steps_left     = 8'd0;
          nxt.delay_count    = 16'd0;
          nxt.motion_mode    = MODE_SEEK;
          status             = STS_ACCEPTED;
        end
      end
      CMD_ABORT: begin
        nxt.abort_latched = 1'b1;
        nxt.motion_mode   = MODE_IDLE;
        nxt.steps_left    = 8'd0;
        nxt.delay_count   = 16'd0;
        status            = STS_ABORT_ACK;
      end
      CMD_CLEAR: begin
        nxt.abort_latched = 1'b0;
        status            = STS_ACCEPTED;
      end
      default: begin
        // tick; unused codes behave the same
        if (cur.motion_mode == MODE_SEEK && cur.delay_count == 16'd0 &&
            !item.zero_sensor) begin
          nxt.motion_mode = MODE_IDLE;
          status          = STS_DONE;
        end else if (moving) begin
          if (step_due) begin
            nxt.delay_count = 16'd0;
            nxt.phase_index = phase_stepped;
            nxt.coil_out    = coil_for_phase(phase_stepped);
            if (cur.motion_mode == MODE_ROTATE) begin
              nxt.steps_left = steps_dec;
              if (steps_dec == 8'd0) begin
                nxt.motion_mode = MODE_IDLE;
                status          = STS_DONE;
              end
            end
          end else begin
            nxt.delay_count = delay_inc;
          end
        end
      end
    endcase
  end

  assign res.coil_pattern = nxt.coil_out;
  assign res.phase        = nxt.phase_index;
  assign res.status       = status;

endmodule

@@ rtl/core/stepper_rotation_with_zero_seek.sv @@
// Four-phase wave-drive stepper controller with seek-to-zero. Each command
// item (tick, rotate, seek, abort, clear abort) gives exactly one result
// item with the active-low coil pattern, the phase and a status. The block
// takes one item per clock cycle sustained while results are taken as they
// come; an item lands in the input register, is evaluated combinationally
// against the motor state, and its result is then registered in the output
// register. While a result waits, the input register takes one more item
// and then the input stalls until the result is taken. step_delay_ticks
// (reset 50) is to be written with cfg_we only while no item is in flight;
// the block itself does not enforce this. A value of zero acts as one.
module stepper_rotation_with_zero_seek import srz_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd_item,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  logic         item_valid;
  cmd_item_t    item;
  logic         advance;
  logic [15:0]  step_delay_ticks;
  motor_state_t state;
  motor_state_t state_next;
  res_item_t    res_next;

  assign advance   = item_valid && (!res_valid || res_ready);
  assign cmd_ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_ready) begin
      item_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      item <= cmd_item;
    end
  end

  // Delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      step_delay_ticks <= cfg_data;
    end
  end

  srz_step u_step (
    .cur              (state),
    .item             (item),
    .step_delay_ticks (step_delay_ticks),
    .nxt              (state_next),
    .res              (res_next)
  );

  // Motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase_index    <= 2'd0;
      state.steps_left     <= 8'd0;
      state.direction_down <= 1'b0;
      state.motion_mode    <= MODE_IDLE;
      state.delay_count    <= 16'd0;
      state.abort_latched  <= 1'b0;
      state.coil_out       <= COILS_OFF;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= res_next;
    end
  end

  // Checks
  a_mode_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state.motion_mode))
    else $error("motion mode not one-hot");

  a_rotate_has_steps: assert property (@(posedge clk) disable iff (rst)
    state.motion_mode == MODE_ROTATE |-> state.steps_left != 8'd0)
    else $error("rotating with no steps left");

  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    state.abort_latched |-> state.motion_mode == MODE_IDLE)
    else $error("motion while abort latched");

  a_idle_delay_clear: assert property (@(posedge clk) disable iff (rst)
    state.motion_mode == MODE_IDLE |-> state.delay_count == 16'd0)
    else $error("delay counter running while idle");

endmodule
